### src/fbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_pkg: shared definitions for the framebuffer rectangle fill block
// Field widths, array geometry, operation codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fbrf_pkg;

  // Array geometry.
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 512;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int OP_W    = 2;
  localparam int ROW_W   = 8;
  localparam int COL_W   = 9;
  localparam int PIX_W   = 8;
  localparam int NROWS_W = 9;
  localparam int NCOLS_W = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NCOLS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_RESULT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic mem_rd;     // read one pixel at the current address
    logic mem_wr;     // write the color at the current address
    logic fill_step;  // advance the fill address
    logic out_load;   // load the result into the output register
  } fbrf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;         // captured operation
    logic pix_ok;     // single pixel address is inside the image
    logic fill_ok;    // rectangle is well formed and inside the image
    logic fill_last;  // current fill address is the last corner
    logic out_busy;   // output register holds a result not yet taken
  } fbrf_stat_t;

endpackage

### src/fbrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_if: channel interfaces of the framebuffer rectangle fill block
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface fbrf_in_if
  import fbrf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [ROW_W-1:0] row_first;
  logic [COL_W-1:0] col_first;
  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] col_last;
  logic [PIX_W-1:0] color;

  modport source (
    output valid, op, row_first, col_first, row_last, col_last, color,
    input  ready
  );
  modport sink (
    input  valid, op, row_first, col_first, row_last, col_last, color,
    output ready
  );
endinterface

interface fbrf_out_if
  import fbrf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] read_data;
  logic             bad_index;

  modport source (
    output valid, read_data, bad_index,
    input  ready
  );
  modport sink (
    input  valid, read_data, bad_index,
    output ready
  );
endinterface

### src/fbrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_ctrl: controller of the framebuffer rectangle fill block
// Sequences accept, check, pixel access or fill sweep, and result hand-off.
// ----------------------------------------------------------------------------
module fbrf_ctrl
  import fbrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fbrf_stat_t stat,
  output fbrf_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        unique case (stat.op)
          OP_READ:  cmd.mem_rd = stat.pix_ok;
          OP_WRITE: cmd.mem_wr = stat.pix_ok;
          OP_FILL: begin
            if (stat.fill_ok) begin
              state_nxt = S_FILL;
            end
          end
          default: ;
        endcase
      end
      S_FILL: begin
        cmd.mem_wr    = 1'b1;
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/fbrf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrf_dp: datapath of the framebuffer rectangle fill block
// Size registers, captured request, address counters, pixel memory and the
// output register.
// ----------------------------------------------------------------------------
module fbrf_dp
  import fbrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [OP_W-1:0]       in_op,
  input  logic [ROW_W-1:0]      in_row_first,
  input  logic [COL_W-1:0]      in_col_first,
  input  logic [ROW_W-1:0]      in_row_last,
  input  logic [COL_W-1:0]      in_col_last,
  input  logic [PIX_W-1:0]      in_color,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_read_data,
  output logic                  out_bad_index,
  input  fbrf_cmd_t             cmd,
  output fbrf_stat_t            stat
);

  logic [NROWS_W-1:0] rows_r;
  logic [NCOLS_W-1:0] cols_r;

  op_t              op_r;
  logic [ROW_W-1:0] row_first_r;
  logic [COL_W-1:0] col_first_r;
  logic [ROW_W-1:0] row_last_r;
  logic [COL_W-1:0] col_last_r;
  logic [PIX_W-1:0] color_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] read_data_r;
  logic             bad_index_r;

  logic [NROWS_W-1:0] eff_rows;
  logic [NCOLS_W-1:0] eff_cols;
  logic [ADDR_W-1:0]  addr;
  logic               bad;
  logic [PIX_W-1:0]   data;

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      cols_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROWS_IN_USE: rows_r <= cfg_wdata[NROWS_W-1:0];
        CFG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sizes above the array saturate to the array.
  assign eff_rows = (rows_r > NROWS_W'(MAX_ROWS)) ? NROWS_W'(MAX_ROWS) : rows_r;
  assign eff_cols = (cols_r > NCOLS_W'(MAX_COLS)) ? NCOLS_W'(MAX_COLS) : cols_r;

  // Captured request and address counters.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= op_t'(in_op);
      row_first_r <= in_row_first;
      col_first_r <= in_col_first;
      row_last_r  <= in_row_last;
      col_last_r  <= in_col_last;
      color_r     <= in_color;
      row_cnt_r   <= in_row_first;
      col_cnt_r   <= in_col_first;
    end else if (cmd.fill_step) begin
      if (col_cnt_r == col_last_r) begin
        col_cnt_r <= col_first_r;
        row_cnt_r <= row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + COL_W'(1);
      end
    end
  end

  assign addr = ADDR_W'(row_cnt_r) * ADDR_W'(MAX_COLS) + ADDR_W'(col_cnt_r);

  // Pixel memory, one port.
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= color_r;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
    end
  end

  assign stat.op        = op_r;
  assign stat.pix_ok    = (NROWS_W'(row_first_r) < eff_rows) &&
                          (NCOLS_W'(col_first_r) < eff_cols);
  assign stat.fill_ok   = (row_first_r < row_last_r) && (col_first_r < col_last_r) &&
                          (NROWS_W'(row_last_r) < eff_rows) &&
                          (NCOLS_W'(col_last_r) < eff_cols);
  assign stat.fill_last = (row_cnt_r == row_last_r) && (col_cnt_r == col_last_r);
  assign stat.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    bad  = 1'b0;
    data = '0;
    case (op_r)
      OP_READ: begin
        bad  = !stat.pix_ok;
        data = stat.pix_ok ? rd_data_r : '0;
      end
      OP_WRITE: bad = !stat.pix_ok;
      OP_FILL:  bad = !stat.fill_ok;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data_r <= data;
      bad_index_r <= bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;
  assign out_bad_index = bad_index_r;

endmodule

### src/framebuffer_rectangle_fill.sv
`timescale 1ns / 1ps
// A read, a write or a rejected item moves from accept through the check state to
// the result state; a fill of N pixels sweeps one pixel per cycle through the one
// port between check and result. The result state waits while the output register
// holds an untaken result, and a new transaction is taken only once it has loaded.
// Reset clears the controller, the output valid flag and both size registers;
// the pixel memory is not cleared and holds undefined values until written.
// ----------------------------------------------------------------------------
// framebuffer_rectangle_fill: 8-bit grayscale framebuffer with rectangle fill
// Serves pixel reads, pixel writes and inclusive rectangle fills on an
// image whose size is set by two configuration registers.
// ----------------------------------------------------------------------------
module framebuffer_rectangle_fill
  import fbrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes: register 0 is rows in use, register 1 columns in use.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request channel, one operation per transaction.
  fbrf_in_if.sink               in_ch,
  // Result channel, exactly one result transaction per request.
  fbrf_out_if.source            out_ch
);

  fbrf_cmd_t  cmd;
  fbrf_stat_t stat;

  // The controller walks each transaction through capture, check, memory
  // access or fill sweep, and result hand-off. The request channel is ready
  // only while the controller is idle, but a finished result may still sit
  // in the output register while the next transaction is taken.
  fbrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the size registers, the captured request, the row and
  // column counters of the fill sweep, the pixel memory and the output
  // register that decouples the result channel.
  fbrf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_ch.op),
    .in_row_first  (in_ch.row_first),
    .in_col_first  (in_ch.col_first),
    .in_row_last   (in_ch.row_last),
    .in_col_last   (in_ch.col_last),
    .in_color      (in_ch.color),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_read_data (out_ch.read_data),
    .out_bad_index (out_ch.bad_index),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
